// ===== rtl/core/qsra_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp average package
// Shared constants, the arctangent table and the CORDIC control word.
// ----------------------------------------------------------------------------
package qsra_pkg;

  localparam int unsigned FRAC_BITS    = 14;
  localparam int unsigned MAX_ITEMS    = 65535;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned ANG_BITS     = 30;

  localparam logic [14:0] ONE       = 15'(1 << FRAC_BITS);
  localparam logic [30:0] HALF_PI   = 31'(1 << ANG_BITS);
  localparam logic [33:0] CORDIC_X0 = 34'd652032874;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      5'd24:   v = 30'd41;
      5'd25:   v = 30'd20;
      5'd26:   v = 30'd10;
      5'd27:   v = 30'd5;
      5'd28:   v = 30'd3;
      5'd29:   v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/qsra_cordic.sv =====
// ----------------------------------------------------------------------------
// CORDIC unit
// One micro-rotation per cycle, in vectoring or rotation mode.
// ----------------------------------------------------------------------------
module qsra_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qsra_pkg::cordic_ctl_t ctl_i,
  input  logic signed [33:0]    x_i,
  input  logic signed [33:0]    y_i,
  input  logic signed [31:0]    z_i,
  output logic                  done_o,
  output logic signed [33:0]    y_o,
  output logic signed [31:0]    z_o
);

  logic signed [33:0] x_q, y_q, dx, dy;
  logic signed [31:0] z_q, at;
  logic [4:0]         step_q;
  logic               busy_q, done_q, vec_q, up;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign at = $signed({2'b00, qsra_pkg::atan_lut(step_q)});
  assign up = vec_q ? (y_q > 34'sd0) : (z_q < 32'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'(qsra_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
      vec_q <= ctl_i.vectoring;
    end else if (busy_q) begin
      if (up) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== rtl/core/qsra_isqrt.sv =====
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qsra_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [28:0] v_i,
  output logic        done_o,
  output logic [14:0] root_o
);

  logic [28:0] v_q, bit_q;
  logic [29:0] res_q, sum;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q;

  assign sum = res_q + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd14) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      res_q <= '0;
      bit_q <= 29'(1) << 28;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= sum) begin
        v_q   <= v_q - sum[28:0];
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[14:0];

endmodule

// ===== rtl/core/qsra_divider.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned long division, one quotient bit per cycle, divisor pre-aligned.
// ----------------------------------------------------------------------------
module qsra_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] dividend_i,
  input  logic [49:0] divisor_i,
  input  logic [4:0]  steps_i,
  output logic        done_o,
  output logic [30:0] quot_o
);

  logic [49:0] rem_q, dsh_q;
  logic [30:0] quot_q;
  logic [4:0]  cnt_q, steps_q;
  logic        busy_q, done_q, ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        steps_q <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == steps_q - 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[29:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/quaternion_slerp_running_average_core.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp running average core
// Folds each quaternion word into a running average by spherical
// interpolation with weight 1/(n+1).
// ----------------------------------------------------------------------------
// One word is taken at a time. The interpolation path runs three 30-step
// passes of the shared CORDIC unit, a 31-step division for the angle split
// and up to four 17-step divisions for the output scaling, none of which the
// midpoint path uses; one 17 by 32 multiplier is shared by the dot product,
// the cosine square and the weighting. The result is held in an output
// register, so a word may be accepted while the previous result is still
// waiting to be taken.
module quaternion_slerp_running_average_core #(
  parameter int unsigned MaxItems = qsra_pkg::MAX_ITEMS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // qw, qx, qy, qz
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // aw, ax, ay, az, items_seen
  output logic        m_axis_tuser,  // midpoint_used
  output logic        m_axis_tlast,  // done_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_DOT, S_NORM, S_CSQ0, S_CSQ1, S_SQRT_W, S_DECIDE, S_ANG_W,
    S_DIV_H, S_HB_W, S_SINA, S_SINA_W, S_SINB, S_SINB_W, S_MUL_A, S_MUL_B,
    S_SUM, S_SCALE, S_QUO_W, S_OUT
  } state_e;

  state_e             state_q;
  logic signed [15:0] avg_q [4];
  logic signed [15:0] res_q [4];
  logic signed [16:0] qb_q [4];
  logic [15:0]        cnt_q, n_next;
  logic [14:0]        thr_q, c_q, s_q;
  logic [2:0]         k_q;
  logic signed [34:0] acc_q;
  logic signed [48:0] prod_q, prod_d;
  logic signed [49:0] num_q;
  logic [30:0]        h_q, hb_q;
  logic signed [31:0] sa_q, sb_q;
  logic               last_q, mid_q, neg_q;
  logic               out_valid_q, out_mid_q, out_last_q;
  logic [79:0]        out_data_q;

  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic [1:0]         ki;
  logic [34:0]        dmag, cfull;
  logic [49:0]        nmag, nrnd;
  logic               ovf, out_free, mid;
  logic [16:0]        nplus;

  qsra_pkg::cordic_ctl_t cctl;
  logic signed [33:0]    cx, cy, cy_out;
  logic signed [31:0]    cz, cz_out;
  logic                  cdone;

  logic        sq_start, sq_done;
  logic [14:0] sq_root;

  logic        dv_start, dv_done;
  logic [49:0] dv_dividend, dv_divisor;
  logic [4:0]  dv_steps;
  logic [30:0] dv_quot;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  assign ki     = k_q[1:0];
  assign n_next = (cnt_q < 16'(MaxItems)) ? cnt_q + 16'd1 : cnt_q;
  assign nplus  = {1'b0, cnt_q} + 17'd1;
  assign mid    = (s_q < thr_q) || (s_q == 15'd0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DOT: begin
        mul_a = 17'(avg_q[ki]);
        mul_b = 32'(qb_q[ki]);
      end
      S_CSQ0: begin
        mul_a = $signed({2'b00, c_q});
        mul_b = $signed({17'd0, c_q});
      end
      S_MUL_A: begin
        mul_a = 17'(avg_q[ki]);
        mul_b = sa_q;
      end
      S_MUL_B: begin
        mul_a = qb_q[ki];
        mul_b = sb_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign dmag  = acc_q[34] ? 35'(-acc_q) : 35'(acc_q);
  assign cfull = (dmag + 35'(1 << (qsra_pkg::FRAC_BITS - 1))) >> qsra_pkg::FRAC_BITS;

  assign nmag = num_q[49] ? 50'(-num_q) : 50'(num_q);
  assign nrnd = nmag + {20'd0, s_q, 15'd0};
  assign ovf  = nrnd >= {2'b00, s_q, 33'd0};

  always_comb begin
    cctl.start     = (state_q == S_DECIDE && !mid) || state_q == S_SINA || state_q == S_SINB;
    cctl.vectoring = state_q == S_DECIDE;
    cx = qsra_pkg::CORDIC_X0;
    cy = '0;
    cz = '0;
    case (state_q)
      S_DECIDE: begin
        cx = $signed({19'd0, c_q});
        cy = $signed({19'd0, s_q});
      end
      S_SINA:  cz = $signed({1'b0, h_q - hb_q});
      S_SINB:  cz = $signed({1'b0, hb_q});
      default: cz = '0;
    endcase
  end

  assign sq_start = state_q == S_CSQ1;

  always_comb begin
    dv_start    = 1'b0;
    dv_dividend = {19'd0, h_q};
    dv_divisor  = {3'd0, nplus, 30'd0};
    dv_steps    = 5'd31;
    case (state_q)
      S_DIV_H: dv_start = 1'b1;
      S_SCALE: begin
        dv_start    = !ovf;
        dv_dividend = nrnd;
        dv_divisor  = {3'd0, s_q, 32'd0};
        dv_steps    = 5'd17;
      end
      default: dv_start = 1'b0;
    endcase
  end

  qsra_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .x_i    (cx),
    .y_i    (cy),
    .z_i    (cz),
    .done_o (cdone),
    .y_o    (cy_out),
    .z_o    (cz_out)
  );

  qsra_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .v_i     (29'(1 << 28) - prod_q[28:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  qsra_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .steps_i    (dv_steps),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      thr_q       <= 15'd2;
      k_q         <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      num_q       <= '0;
      c_q         <= '0;
      s_q         <= '0;
      h_q         <= '0;
      hb_q        <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      last_q      <= 1'b0;
      mid_q       <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_mid_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        avg_q[i] <= '0;
        res_q[i] <= '0;
        qb_q[i]  <= '0;
      end
    end else begin
      prod_q <= prod_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < 4; i++) begin
              qb_q[i] <= 17'($signed(s_axis_tdata[16*i +: 16]));
            end
            last_q  <= s_axis_tlast;
            acc_q   <= '0;
            k_q     <= '0;
            state_q <= S_DOT;
          end
        end
        S_DOT: begin
          if (k_q != 3'd0) begin
            acc_q <= acc_q + prod_q[34:0];
          end
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (acc_q[34]) begin
            for (int i = 0; i < 4; i++) begin
              qb_q[i] <= -qb_q[i];
            end
          end
          c_q     <= (cfull > 35'(qsra_pkg::ONE)) ? qsra_pkg::ONE : cfull[14:0];
          state_q <= S_CSQ0;
        end
        S_CSQ0:   state_q <= S_CSQ1;
        S_CSQ1:   state_q <= S_SQRT_W;
        S_SQRT_W: begin
          if (sq_done) begin
            s_q     <= sq_root;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          mid_q <= mid;
          if (mid) begin
            for (int i = 0; i < 4; i++) begin
              res_q[i] <= sat16((18'(avg_q[i]) + 18'(qb_q[i])) >>> 1);
            end
            state_q <= S_OUT;
          end else begin
            state_q <= S_ANG_W;
          end
        end
        S_ANG_W: begin
          if (cdone) begin
            if (cz_out < 32'sd0) begin
              h_q <= '0;
            end else if (cz_out > $signed({1'b0, qsra_pkg::HALF_PI})) begin
              h_q <= qsra_pkg::HALF_PI;
            end else begin
              h_q <= cz_out[30:0];
            end
            state_q <= S_DIV_H;
          end
        end
        S_DIV_H: state_q <= S_HB_W;
        S_HB_W: begin
          if (dv_done) begin
            hb_q    <= dv_quot;
            state_q <= S_SINA;
          end
        end
        S_SINA:   state_q <= S_SINA_W;
        S_SINA_W: begin
          if (cdone) begin
            sa_q    <= cy_out[31:0];
            state_q <= S_SINB;
          end
        end
        S_SINB:   state_q <= S_SINB_W;
        S_SINB_W: begin
          if (cdone) begin
            sb_q    <= cy_out[31:0];
            k_q     <= '0;
            state_q <= S_MUL_A;
          end
        end
        S_MUL_A: state_q <= S_MUL_B;
        S_MUL_B: begin
          num_q   <= 50'(prod_q);
          state_q <= S_SUM;
        end
        S_SUM: begin
          num_q   <= num_q + 50'(prod_q);
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          neg_q <= num_q[49];
          if (ovf) begin
            res_q[ki] <= num_q[49] ? 16'sh8000 : 16'sh7fff;
            k_q       <= k_q + 3'd1;
            state_q   <= (ki == 2'd3) ? S_OUT : S_MUL_A;
          end else begin
            state_q <= S_QUO_W;
          end
        end
        S_QUO_W: begin
          if (dv_done) begin
            if (neg_q) begin
              res_q[ki] <= (dv_quot[16:0] > 17'd32768) ? 16'sh8000
                         : 16'(-$signed({1'b0, dv_quot[16:0]}));
            end else begin
              res_q[ki] <= (dv_quot[16:0] > 17'd32767) ? 16'sh7fff : dv_quot[15:0];
            end
            k_q     <= k_q + 3'd1;
            state_q <= (ki == 2'd3) ? S_OUT : S_MUL_A;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {n_next, res_q[3], res_q[2], res_q[1], res_q[0]};
            out_mid_q   <= mid_q;
            out_last_q  <= last_q;
            for (int i = 0; i < 4; i++) begin
              avg_q[i] <= last_q ? 16'sd0 : res_q[i];
            end
            cnt_q   <= last_q ? 16'd0 : n_next;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_mid_q;
  assign m_axis_tlast  = out_last_q;
  assign cfg_ready_o   = 1'b1;

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_q <= qsra_pkg::ONE) else $error("cosine above one");

  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q <= qsra_pkg::ONE) else $error("sine above one");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 16'(MaxItems)) else $error("item count beyond limit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == S_DOT)
    else $error("accepted word did not start the dot product");

endmodule
